/* hdl/adsr_pkg.sv */
// Shared constants, codes and types for the one-pole ADSR envelope block.
// Holds the fixed-point constants, the table of fractional powers of two and
// the divider status type. No dependencies.
package adsr_pkg;

	localparam int ENV_FRAC_BITS = 30;

	localparam logic [63:0] ONE_ONE = ((64'd11 << ENV_FRAC_BITS) + 64'd5) / 64'd10;
	localparam logic [63:0] THRESH = ((64'd99 << ENV_FRAC_BITS) + 64'd50) / 64'd100;
	localparam logic [31:0] KQ28 = 32'd1647099329;

	localparam logic [1:0] PH_RELEASE = 2'd0;
	localparam logic [1:0] PH_ATTACK = 2'd1;
	localparam logic [1:0] PH_DECAY = 2'd2;

	localparam logic [2:0] REG_ATTACK = 3'd0;
	localparam logic [2:0] REG_DECAY = 3'd1;
	localparam logic [2:0] REG_SUSTAIN = 3'd2;
	localparam logic [2:0] REG_RELEASE = 3'd3;
	localparam logic [2:0] REG_RATE = 3'd4;

	typedef logic [14:0][31:0] root_tab_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// integer square root, one result bit per pass
	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] r;
		logic [63:0] b;
		rem = x;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// entry j is 2^(2^j / 32768) in Q1.31
	function automatic root_tab_t build_roots();
		root_tab_t t;
		logic [63:0] cur;
		cur = isqrt64(64'd1 << 63);
		t[14] = cur[31:0];
		for (int j = 14; j > 0; j--) begin
			cur = isqrt64({cur[32:0], 31'd0});
			t[j-1] = cur[31:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOT_TAB = build_roots();

endpackage

/* hdl/adsr_mul.sv */
// Shared 32x32 multiplier with a registered product.
// Depends on nothing but the clock; product holds until the next enable.
module adsr_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod_q
);
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= 64'(a) * 64'(b);
		end
	end
endmodule

/* hdl/adsr_div.sv */
// Bit-serial restoring divider: 64-bit dividend by 18-bit divisor, one
// quotient bit per cycle. Uses adsr_pkg for the status type.
module adsr_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [63:0]          dividend,
	input  logic [17:0]          divisor,
	output adsr_pkg::div_stat_t  stat,
	output logic [63:0]          quotient
);
	import adsr_pkg::*;

	logic [63:0] quo_q;
	logic [17:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [18:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[63]};
	assign fits = trial >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 18'(trial - {1'b0, divisor}) : trial[17:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign quotient = quo_q;
endmodule

/* hdl/adsr_envelope_one_pole.sv */
// Top level of the one-pole ADSR envelope generator: sequencer, registers
// and result slot. Uses adsr_pkg, adsr_mul and adsr_div.
//
// Usage: each input transfer carries one gate bit for one audio sample and
// produces exactly one output transfer with the new envelope (Q1.30) and the
// new phase (0 release, 1 attack, 2 decay/sustain). Both channels use
// valid/ready. Registers are written through cfg_write/cfg_index/cfg_data,
// one register per cycle. The user must write them only while no sample is
// in flight; the block itself does not enforce this. Each sample steps
// through the fractional power of two on the shared multiplier, one multiply
// per set bit of the time-level fraction, then the scaling multiply, the
// 64-step serial divider by the sample rate and the update multiply.
// With a zero sample rate the divider is skipped.
// One sample is processed at a time; in_ready is high only between samples.
// A finished result waits in the output register; a new sample may be taken
// while it waits, but its own result is held back until the slot is free.
// Reset clears the envelope to zero, the phase to release and the
// registers to their defaults (attack, decay, release -0.5, sustain 0.5,
// 48000 Hz).
module adsr_envelope_one_pole (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        gate,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] envelope,
	output logic [1:0]  phase,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);
	import adsr_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ROOT = 4'd1;
	localparam logic [3:0] ST_ROOT_TAKE = 4'd2;
	localparam logic [3:0] ST_KQ_ISSUE = 4'd3;
	localparam logic [3:0] ST_KQ_TAKE = 4'd4;
	localparam logic [3:0] ST_DIV = 4'd5;
	localparam logic [3:0] ST_UPD_ISSUE = 4'd6;
	localparam logic [3:0] ST_UPD_TAKE = 4'd7;

	logic [15:0] attack_q, decay_q, sustain_q, release_q;
	logic [17:0] rate_q;

	logic [3:0]  state_q;
	logic [31:0] env_q;
	logic [1:0]  phase_q;
	logic [1:0]  next_q;
	logic [31:0] tgt_q;
	logic [30:0] d_q;
	logic        up_q;
	logic [14:0] f_q;
	logic [5:0]  sh_q;
	logic [3:0]  j_q;
	logic [31:0] p_q;
	logic [31:0] coef_q;
	logic        out_valid_q;
	logic [30:0] out_env_q;
	logic [1:0]  out_phase_q;

	// step decision from the phase before the move
	logic [1:0]  nx;
	logic [31:0] tgt;
	logic [15:0] tl;
	logic signed [20:0] u;
	logic [31:0] sus_tgt;

	logic        mul_en;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [63:0] p_round, m_round;
	logic        div_start;
	div_stat_t   div_stat;
	logic [63:0] quo;
	logic [63:0] q_sh;
	logic        slot_free;
	logic        in_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign sus_tgt = 32'(64'(sustain_q) << (ENV_FRAC_BITS - 15));

	always_comb begin
		nx = phase_q;
		priority case (phase_q)
			PH_ATTACK: begin
				if (64'(env_q) > THRESH) begin
					nx = PH_DECAY;
				end else if (!gate) begin
					nx = PH_RELEASE;
				end
				tgt = ONE_ONE[31:0];
				tl = attack_q;
			end
			PH_DECAY: begin
				if (!gate) begin
					nx = PH_RELEASE;
				end
				tgt = sus_tgt;
				tl = decay_q;
			end
			default: begin
				nx = gate ? PH_ATTACK : PH_RELEASE;
				tgt = '0;
				tl = release_q;
			end
		endcase
		u = 21'sd327680 - (21'(signed'(tl)) <<< 3) - (21'(signed'(tl)) <<< 1);
	end

	always_comb begin
		mul_en = 1'b0;
		mul_a = p_q;
		mul_b = ROOT_TAB[j_q];
		unique case (state_q)
			ST_ROOT: mul_en = (j_q != 4'd15) && f_q[j_q];
			ST_KQ_ISSUE: begin
				mul_en = 1'b1;
				mul_b = KQ28;
			end
			ST_UPD_ISSUE: begin
				mul_en = 1'b1;
				mul_a = {1'b0, d_q};
				mul_b = coef_q;
			end
			default: mul_en = 1'b0;
		endcase
	end

	adsr_mul u_mul (
		.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .prod_q(prod)
	);

	assign div_start = (state_q == ST_KQ_TAKE) && (rate_q != '0);

	adsr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(prod),
		.divisor(rate_q), .stat(div_stat), .quotient(quo)
	);

	assign p_round = prod + (64'd1 << 30);
	assign m_round = prod + (64'd1 << 31);
	assign q_sh = quo >> sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= 16'hC000;
			decay_q <= 16'hC000;
			sustain_q <= 16'd16384;
			release_q <= 16'hC000;
			rate_q <= 18'd48000;
		end else if (cfg_write) begin
			priority case (cfg_index)
				REG_ATTACK: attack_q <= cfg_data[15:0];
				REG_DECAY: decay_q <= cfg_data[15:0];
				REG_SUSTAIN: sustain_q <= cfg_data[15:0];
				REG_RELEASE: release_q <= cfg_data[15:0];
				REG_RATE: rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// payload of the step in flight
	always_ff @(posedge clk) begin
		if (in_fire) begin
			next_q <= nx;
			tgt_q <= tgt;
			up_q <= tgt >= env_q;
			d_q <= (tgt >= env_q) ? 31'(tgt - env_q) : 31'(env_q - tgt);
			f_q <= u[14:0];
			sh_q <= 6'd37 - 6'(u[19:15]);
			p_q <= 32'h8000_0000;
		end else if (state_q == ST_ROOT_TAKE) begin
			p_q <= p_round[62:31];
		end
		if (state_q == ST_KQ_TAKE && rate_q == '0) begin
			coef_q <= '1;
		end else if (state_q == ST_DIV && div_stat.done) begin
			coef_q <= (q_sh[63:32] != '0) ? '1 : q_sh[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			env_q <= '0;
			phase_q <= PH_RELEASE;
			j_q <= '0;
			out_valid_q <= 1'b0;
			out_env_q <= '0;
			out_phase_q <= PH_RELEASE;
		end else begin
			// drop the slot on transfer unless a new result refills it
			if (out_valid_q && out_ready && state_q != ST_UPD_TAKE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						j_q <= '0;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (j_q == 4'd15) begin
						state_q <= ST_KQ_ISSUE;
					end else if (f_q[j_q]) begin
						state_q <= ST_ROOT_TAKE;
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				ST_ROOT_TAKE: begin
					j_q <= j_q + 4'd1;
					state_q <= ST_ROOT;
				end
				ST_KQ_ISSUE: state_q <= ST_KQ_TAKE;
				ST_KQ_TAKE: state_q <= (rate_q == '0) ? ST_UPD_ISSUE : ST_DIV;
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_UPD_ISSUE;
					end
				end
				ST_UPD_ISSUE: state_q <= ST_UPD_TAKE;
				ST_UPD_TAKE: begin
					// hold until the result slot is free
					if (slot_free) begin
						env_q <= up_q ? env_q + m_round[63:32] : env_q - m_round[63:32];
						out_env_q <= up_q ? 31'(env_q + m_round[63:32])
						                  : 31'(env_q - m_round[63:32]);
						phase_q <= next_q;
						out_phase_q <= next_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign envelope = out_env_q;
	assign phase = out_phase_q;

`ifndef NO_ASSERTIONS
	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!env_q[31]) else $error("envelope passed its target");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready) else $error("second sample taken while busy");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV) else $error("stray divider completion");
	a_tgt_side: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD_ISSUE |-> (up_q == (tgt_q >= env_q)))
		else $error("update direction disagrees with target");
`endif
endmodule

/* bench/tb.sv */
// Self-checking bench for the one-pole ADSR envelope block: gate transfers in,
// envelope/phase transfers out, compared against an in-bench predictor.
// Depends on adsr_pkg and the adsr_envelope_one_pole RTL.
`timescale 1ns / 100ps

module tb;
	import adsr_pkg::*;

	typedef struct {
		logic [30:0] env;
		logic [1:0]  ph;
	} env_result_t;

	typedef struct {
		bit          gate;
		bit          typed;
		logic [30:0] env;
		logic [1:0]  ph;
	} gate_row_t;

	localparam int SETTLE = 120;
	localparam int HOLD_OFF = 400;
	localparam int STALL_LIMIT = 6000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        gate;
	logic        out_valid;
	logic        out_ready;
	logic [30:0] envelope;
	logic [1:0]  phase;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [17:0] cfg_data;

	// predictor state and register copies
	logic [15:0] att_lvl, dec_lvl, sus_lvl, rel_lvl;
	logic [17:0] rate_hz;
	logic [31:0] env_now;
	logic [1:0]  ph_now;
	logic [63:0] pow_roots [15];

	env_result_t pending_env [$];
	int errors;
	int send_idle_pct;
	int stall_pct;
	bit hold_req;

	adsr_envelope_one_pole uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .gate(gate),
		.out_valid(out_valid), .out_ready(out_ready),
		.envelope(envelope), .phase(phase),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] sqrt_floor(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] t;
		r = 64'd0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [63:0] pole_coef(logic [15:0] lvl);
		int          v;
		int          n;
		logic [31:0] u;
		logic [63:0] p;
		logic [63:0] q;
		v = $signed(lvl);
		u = 327680 - 10 * v;
		n = int'(u >> 15) - 10;
		p = 64'd1 << 31;
		for (int j = 0; j < 15; j++)
			if (u[j])
				p = (p * pow_roots[j] + (64'd1 << 30)) >> 31;
		if (rate_hz == 0)
			return 64'hFFFF_FFFF;
		q = (64'd1647099329 * p) / rate_hz;
		q = q >> (27 - n);
		if (q > 64'hFFFF_FFFF)
			q = 64'hFFFF_FFFF;
		return q;
	endfunction

	// advance the envelope by one sample and return what the block must emit
	function automatic env_result_t envelope_step(bit g);
		logic [63:0] one_one, thresh, target, z, d, m, c;
		logic [15:0] tl;
		logic [1:0]  nxt;
		env_result_t r;
		one_one = ((64'd11 << 30) + 64'd5) / 64'd10;
		thresh = ((64'd99 << 30) + 64'd50) / 64'd100;
		z = env_now;
		nxt = ph_now;
		if (ph_now == PH_ATTACK) begin
			if (z > thresh)
				nxt = PH_DECAY;
			else if (!g)
				nxt = PH_RELEASE;
			target = one_one;
			tl = att_lvl;
		end else if (ph_now == PH_DECAY) begin
			if (!g)
				nxt = PH_RELEASE;
			target = 64'(sus_lvl) << 15;
			tl = dec_lvl;
		end else begin
			nxt = g ? PH_ATTACK : PH_RELEASE;
			target = 64'd0;
			tl = rel_lvl;
		end
		c = pole_coef(tl);
		if (target >= z) begin
			d = target - z;
			m = (d * c + (64'd1 << 31)) >> 32;
			z = z + m;
		end else begin
			d = z - target;
			m = (d * c + (64'd1 << 31)) >> 32;
			z = z - m;
		end
		env_now = z[31:0];
		ph_now = nxt;
		r.env = z[30:0];
		r.ph = nxt;
		return r;
	endfunction

	// offer one gate bit, hold it until the transfer, then queue the expectation
	task automatic send_gate(bit g, bit typed = 0, logic [30:0] t_env = '0,
			logic [1:0] t_ph = '0);
		env_result_t r;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			gate <= $urandom_range(1);
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		gate <= g;
		do @(posedge clk); while (!in_ready);
		r = envelope_step(g);
		if (typed) begin
			r.env = t_env;
			r.ph = t_ph;
		end
		pending_env.push_back(r);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (pending_env.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [17:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ATTACK:  att_lvl = val[15:0];
			REG_DECAY:   dec_lvl = val[15:0];
			REG_SUSTAIN: sus_lvl = val[15:0];
			REG_RELEASE: rel_lvl = val[15:0];
			REG_RATE:    rate_hz = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	function automatic logic [17:0] pick_level();
		case ($urandom_range(5))
			0: return 18'h08000;
			1: return 18'h07FFF;
			2: return 18'($urandom_range(16'hFFFF)) | 18'h30000;
			3: return 18'(-$urandom_range(32768, 4096));
			default: return 18'($urandom_range(16'hFFFF));
		endcase
	endfunction

	function automatic logic [17:0] pick_rate();
		case ($urandom_range(7))
			0: return 18'd8000;
			1: return 18'd192000;
			2: return 18'h3FFFF;
			3: return 18'($urandom_range(3));
			default: return 18'($urandom_range(192000, 8000));
		endcase
	endfunction

	function automatic logic [17:0] pick_sustain();
		case ($urandom_range(4))
			0: return 18'd0;
			1: return 18'd32768;
			2: return 18'h3FFFF;
			default: return 18'($urandom_range(32768));
		endcase
	endfunction

	task automatic write_all(logic [17:0] a, logic [17:0] d, logic [17:0] s,
			logic [17:0] r, logic [17:0] hz);
		write_reg(REG_ATTACK, a);
		write_reg(REG_DECAY, d);
		write_reg(REG_SUSTAIN, s);
		write_reg(REG_RELEASE, r);
		write_reg(REG_RATE, hz);
		cfg_write <= 1'b0;
	endtask

	// compare every output transfer against the oldest expectation
	always @(posedge clk) begin
		env_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_env.size() == 0) begin
				$display("%0t: unexpected result env=%h phase=%0d", $time, envelope, phase);
				errors++;
			end else begin
				e = pending_env.pop_front();
				if (envelope !== e.env) begin
					$display("%0t: envelope expected %h actual %h", $time, e.env, envelope);
					errors++;
				end
				if (phase !== e.ph) begin
					$display("%0t: phase expected %0d actual %0d", $time, e.ph, phase);
					errors++;
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
			end
			out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		gate_row_t   at_reset [] = '{
			'{0, 1, 31'd0, PH_RELEASE}, '{1, 1, 31'd0, PH_ATTACK},
			'{1, 0, 0, 0}, '{1, 0, 0, 0}, '{1, 0, 0, 0}, '{1, 0, 0, 0},
			'{1, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
			'{1, 0, 0, 0}, '{1, 0, 0, 0}
		};
		gate_row_t   fast_rows [] = '{
			'{1, 0, 0, 0}, '{1, 0, 0, 0}, '{1, 0, 0, 0}, '{1, 0, 0, 0},
			'{1, 0, 0, 0}, '{1, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
			'{1, 0, 0, 0}, '{1, 0, 0, 0}, '{1, 0, 0, 0}, '{0, 0, 0, 0}
		};
		int          run_len;
		bit          g;
		bit          hold_done;
		bit          pause_done;
		errors = 0;
		hold_req = 0;
		hold_done = 0;
		pause_done = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		in_valid = 1'b0;
		gate = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_ATTACK;
		cfg_data = '0;
		att_lvl = 16'hC000;
		dec_lvl = 16'hC000;
		sus_lvl = 16'd16384;
		rel_lvl = 16'hC000;
		rate_hz = 18'd48000;
		env_now = '0;
		ph_now = PH_RELEASE;
		pow_roots[14] = sqrt_floor(64'd1 << 63);
		for (int j = 14; j > 0; j--)
			pow_roots[j-1] = sqrt_floor(pow_roots[j] << 31);

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (at_reset[i])
			send_gate(at_reset[i].gate, at_reset[i].typed, at_reset[i].env, at_reset[i].ph);
		drain();
		// fastest times, zero rate, sustain above one, junk in spare indexes
		write_reg(3'd5, 18'h3FFFF);
		write_reg(3'd7, 18'h15555);
		write_all(18'h08000, 18'h08000, 18'h3FFFF, 18'h08000, 18'd0);
		foreach (fast_rows[i])
			send_gate(fast_rows[i].gate);
		drain();
		write_all(18'h07FFF, 18'h07FFF, 18'd0, 18'h07FFF, 18'd1);
		send_gate(1);
		send_gate(1);
		send_gate(0);
		drain();

		for (int ph_i = 0; ph_i < 12; ph_i++) begin
			case (ph_i % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 84; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 84; end
				default: begin send_idle_pct = 29; stall_pct = 29; end
			endcase
			if (ph_i == 0)
				write_all(18'h08000, 18'h07FFF, 18'd32768, 18'h08000, 18'd192000);
			else if (ph_i == 1)
				write_all(18'h07FFF, 18'h08000, 18'd0, 18'h07FFF, 18'd8000);
			else
				write_all(pick_level(), pick_level(), pick_sustain(), pick_level(),
					pick_rate());
			pause_done = 0;
			for (int k = 0; k < 160; ) begin
				if (ph_i == 4 && k >= 40 && !hold_done) begin
					hold_req = 1;
					hold_done = 1;
				end
				if (k >= 100 && !pause_done) begin
					// let every result come home before going on
					pause_done = 1;
					in_valid <= 1'b0;
					wait (pending_env.size() == 0);
					@(negedge clk);
				end
				if ($urandom_range(9) == 0) begin
					send_gate($urandom_range(1));
					k++;
				end else begin
					g = ~g;
					run_len = g ? $urandom_range(60, 1) : $urandom_range(30, 1);
					for (int r = 0; r < run_len && k < 160; r++, k++)
						send_gate(g);
				end
			end
			drain();
		end

		stall_pct = 0;
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* adsr_envelope_one_pole.f */
hdl/adsr_pkg.sv
hdl/adsr_mul.sv
hdl/adsr_div.sv
hdl/adsr_envelope_one_pole.sv
bench/tb.sv
